// File: hdl/ptp_pkg.sv
// shared types and constants of the point/triangle proximity test
// no dependencies
package ptp_pkg;

	localparam int COORD_BITS_DEF = 32;
	localparam int QUEUE_DEPTH = 4;
	localparam int IN_BITS = 32;
	localparam int CFG_BITS = 31;

	localparam logic [2:0] MODE_V0 = 3'd0;
	localparam logic [2:0] MODE_V1 = 3'd1;
	localparam logic [2:0] MODE_V2 = 3'd2;
	localparam logic [2:0] MODE_NORM = 3'd3;
	localparam logic [2:0] MODE_TEST = 3'd4;

	localparam logic REG_NEAR = 1'b0;
	localparam logic REG_MINLEN = 1'b1;

	localparam logic [CFG_BITS-1:0] NEAR_RESET = 31'd65536;
	localparam logic [CFG_BITS-1:0] MINLEN_RESET = 31'd32768;

	typedef struct packed {
		logic [2:0] kind;
		logic [IN_BITS-1:0] x;
		logic [IN_BITS-1:0] y;
		logic [IN_BITS-1:0] z;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic [$clog2(QUEUE_DEPTH+1)-1:0] count;
	} q_stat_t;

endpackage

// File: hdl/ptp_front.sv
// front part: takes input transfers and classifies them by mode
// depends on ptp_pkg
module ptp_front (
	input  logic in_valid,
	output logic in_ready,
	input  logic [2:0] mode,
	input  logic [ptp_pkg::IN_BITS-1:0] coord_x,
	input  logic [ptp_pkg::IN_BITS-1:0] coord_y,
	input  logic [ptp_pkg::IN_BITS-1:0] coord_z,
	input  ptp_pkg::q_stat_t q_stat,
	output logic push,
	output ptp_pkg::item_t item
);
	import ptp_pkg::*;

	logic known;

	always_comb begin
		unique case (mode) inside
			MODE_V0, MODE_V1, MODE_V2, MODE_NORM, MODE_TEST: known = 1'b1;
			default: known = 1'b0;
		endcase
	end

	assign in_ready = !q_stat.full;
	assign push = in_valid && in_ready && known;
	assign item = '{kind: mode, x: coord_x, y: coord_y, z: coord_z};

endmodule

// File: hdl/ptp_queue.sv
// short queue between front and back parts
// depends on ptp_pkg
module ptp_queue #(
	parameter int DEPTH = ptp_pkg::QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  ptp_pkg::item_t wr_item,
	input  logic pop,
	output ptp_pkg::item_t rd_item,
	output ptp_pkg::q_stat_t stat
);
	import ptp_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH+1);

	item_t slot_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	function automatic logic [PW-1:0] nxt(input logic [PW-1:0] p);
		nxt = (p == PW'(DEPTH-1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_ptr_q <= nxt(wr_ptr_q);
			if (pop) rd_ptr_q <= nxt(rd_ptr_q);
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= wr_item;
	end

	assign rd_item = slot_q[rd_ptr_q];
	assign stat.count = count_q;
	assign stat.full = (count_q == CW'(DEPTH));
	assign stat.empty = (count_q == '0);

endmodule

// File: hdl/ptp_back.sv
// back part: triangle registers, the pipelined proximity test and its sliced multiplier
// depends on ptp_pkg
module ptp_mul #(
	parameter int WA = 33,
	parameter int WB = 33,
	parameter int WP = 66
) (
	input  logic clk,
	input  logic en,
	input  logic signed [WA-1:0] a,
	input  logic signed [WB-1:0] b,
	output logic signed [WP-1:0] p
);
	localparam int L = 32;
	localparam int NA = (WA + L - 1) / L;
	localparam int NB = (WB + L - 1) / L;
	localparam int XA = NA * L;
	localparam int XB = NB * L;
	localparam int PPW = 2 * L + 2;

	logic signed [XA-1:0] ax;
	logic signed [XB-1:0] bx;
	logic signed [L:0] la [NA];
	logic signed [L:0] lb [NB];
	logic signed [PPW-1:0] pp_s1 [NA][NB];
	logic signed [WP-1:0] row [NA];
	logic signed [WP-1:0] row_s2 [NA];
	logic signed [WP-1:0] tot;
	logic signed [WP-1:0] prod_s3;

	assign ax = XA'(a);
	assign bx = XB'(b);

	// 32 bit limbs, only the top limb carries the sign
	always_comb begin
		for (int i = 0; i < NA; i++)
			la[i] = {(i == NA - 1) ? ax[i * L + L - 1] : 1'b0, ax[i * L +: L]};
		for (int j = 0; j < NB; j++)
			lb[j] = {(j == NB - 1) ? bx[j * L + L - 1] : 1'b0, bx[j * L +: L]};
	end

	always_comb begin
		for (int i = 0; i < NA; i++) begin
			row[i] = '0;
			for (int j = 0; j < NB; j++)
				row[i] = row[i] + (WP'(pp_s1[i][j]) <<< (j * L));
		end
		tot = '0;
		for (int i = 0; i < NA; i++)
			tot = tot + (row_s2[i] <<< (i * L));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NA; i++) begin
				for (int j = 0; j < NB; j++)
					pp_s1[i][j] <= PPW'(la[i]) * PPW'(lb[j]);
				row_s2[i] <= row[i];
			end
			prod_s3 <= tot;
		end
	end

	assign p = prod_s3;

endmodule

module ptp_back #(
	parameter int COORD_BITS = ptp_pkg::COORD_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic cfg_addr,
	input  logic [ptp_pkg::CFG_BITS-1:0] cfg_wdata,
	input  ptp_pkg::q_stat_t q_stat,
	input  ptp_pkg::item_t item,
	output logic pop,
	output logic out_valid,
	input  logic out_ready,
	output logic hit
);
	import ptp_pkg::*;

	localparam int C = COORD_BITS;
	localparam int D = C + 1;
	localparam int P2 = 2 * D;
	localparam int S2 = P2 + 2;
	localparam int W3 = S2 + D + 1;
	localparam int P4 = D + W3;
	localparam int S4 = P4 + 2;
	localparam int P6 = S2 + S4 + 2;
	localparam int SQ = 2 * CFG_BITS;

	logic signed [C-1:0] vert_q [3][3];
	logic signed [C-1:0] norm_q [3];
	logic [CFG_BITS-1:0] near_q, minlen_q;
	logic signed [C-1:0] pw [3];
	logic en;
	logic [14:1] vld;

	logic signed [C-1:0] n_s1 [3], n_s2 [3], n_s3 [3], n_s4 [3], n_s5 [3], n_s6 [3], n_s7 [3];
	logic signed [D-1:0] d_s1 [3];
	logic signed [D-1:0] e_s1 [3][3], e_s2 [3][3], e_s3 [3][3];
	logic signed [D-1:0] c_s1 [3][3], c_s2 [3][3], c_s3 [3][3], c_s4 [3][3];
	logic signed [D-1:0] c_s5 [3][3], c_s6 [3][3], c_s7 [3][3];
	logic signed [D-1:0] q_s1 [3][3], q_s2 [3][3], q_s3 [3][3], q_s4 [3][3];
	logic signed [D-1:0] q_s5 [3][3], q_s6 [3][3], q_s7 [3][3];
	logic signed [P2-1:0] nsq_s2 [3], dnp_s2 [3], eep_s2 [3][3], cep_s2 [3][3];
	logic [SQ-1:0] mn2_s2, nr2_s2, nr2_s3;
	logic signed [S2-1:0] nn_s3, dn_s3, ee_s3 [3], ce_s3 [3];
	logic signed [S2-1:0] nn_s4, dn_s4, nn_s5, dn_s5, nn_s6, dn_s6, nn_s7, dn_s7;
	logic signed [S2-1:0] nn_s8, dn_s8, nn_s9, dn_s9, nn_s10, dn_s10, nn_s11, dn_s11;
	logic ok_s3, ok_s4, ok_s5, ok_s6, ok_s7, ok_s8, ok_s9, ok_s10;
	logic ok_s11, ok_s12, ok_s13, ok_s14;
	logic signed [P6-1:0] nrn_s6, dn2_s6;
	logic signed [W3-1:0] ecp_s6 [3][3], cep_s6 [3][3], w_s7 [3][3];
	logic signed [P4-1:0] cwp_s10 [3][3], qwp_s10 [3][3], nwp_s10 [3][3];
	logic signed [S4-1:0] qw_s11 [3], nw_s11 [3];
	logic signed [P6-1:0] a_s14 [3], b_s14 [3];
	logic out_valid_q, hit_q;
	logic fin_ok;

	function automatic logic signed [C-1:0] wrap(input logic [IN_BITS-1:0] r);
		wrap = C'($signed(r));
	endfunction

	assign en = !out_valid_q || out_ready;
	assign pop = en && !q_stat.empty;
	assign pw[0] = wrap(item.x);
	assign pw[1] = wrap(item.y);
	assign pw[2] = wrap(item.z);

	// triangle and config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				norm_q[k] <= '0;
				for (int i = 0; i < 3; i++) vert_q[k][i] <= '0;
			end
			near_q <= NEAR_RESET;
			minlen_q <= MINLEN_RESET;
		end else begin
			if (cfg_we) begin
				unique case (cfg_addr)
					REG_NEAR: near_q <= cfg_wdata;
					REG_MINLEN: minlen_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (pop) begin
				unique case (item.kind)
					MODE_V0: for (int i = 0; i < 3; i++) vert_q[0][i] <= pw[i];
					MODE_V1: for (int i = 0; i < 3; i++) vert_q[1][i] <= pw[i];
					MODE_V2: for (int i = 0; i < 3; i++) vert_q[2][i] <= pw[i];
					MODE_NORM: for (int i = 0; i < 3; i++) norm_q[i] <= pw[i];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			vld <= {vld[13:1], pop && (item.kind == MODE_TEST)};
			out_valid_q <= vld[14];
		end
	end

	always_comb begin
		fin_ok = ok_s14;
		for (int k = 0; k < 3; k++)
			if (a_s14[k] - b_s14[k] <= 0) fin_ok = 1'b0;
	end

	// wide products, three stages each
	ptp_mul #(.WA(SQ + 1), .WB(S2), .WP(P6)) u_mul_nrn (
		.clk(clk), .en(en), .a($signed({1'b0, nr2_s3})), .b(nn_s3), .p(nrn_s6)
	);

	ptp_mul #(.WA(S2), .WB(S2), .WP(P6)) u_mul_dn2 (
		.clk(clk), .en(en), .a(dn_s3), .b(dn_s3), .p(dn2_s6)
	);

	for (genvar k = 0; k < 3; k++) begin : g_edge
		ptp_mul #(.WA(S2), .WB(S4), .WP(P6)) u_mul_a (
			.clk(clk), .en(en), .a(nn_s11), .b(qw_s11[k]), .p(a_s14[k])
		);
		ptp_mul #(.WA(S2), .WB(S4), .WP(P6)) u_mul_b (
			.clk(clk), .en(en), .a(dn_s11), .b(nw_s11[k]), .p(b_s14[k])
		);
		for (genvar i = 0; i < 3; i++) begin : g_comp
			ptp_mul #(.WA(S2), .WB(D), .WP(W3)) u_mul_ec (
				.clk(clk), .en(en), .a(ee_s3[k]), .b(c_s3[k][i]), .p(ecp_s6[k][i])
			);
			ptp_mul #(.WA(S2), .WB(D), .WP(W3)) u_mul_ce (
				.clk(clk), .en(en), .a(ce_s3[k]), .b(e_s3[k][i]), .p(cep_s6[k][i])
			);
			ptp_mul #(.WA(D), .WB(W3), .WP(P4)) u_mul_cw (
				.clk(clk), .en(en), .a(c_s7[k][i]), .b(w_s7[k][i]), .p(cwp_s10[k][i])
			);
			ptp_mul #(.WA(D), .WB(W3), .WP(P4)) u_mul_qw (
				.clk(clk), .en(en), .a(q_s7[k][i]), .b(w_s7[k][i]), .p(qwp_s10[k][i])
			);
			ptp_mul #(.WA(C), .WB(W3), .WP(P4)) u_mul_nw (
				.clk(clk), .en(en), .a(n_s7[i]), .b(w_s7[k][i]), .p(nwp_s10[k][i])
			);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// s1: differences
			for (int k = 0; k < 3; k++) begin
				n_s1[k] <= norm_q[k];
				d_s1[k] <= D'(pw[k]) - D'(vert_q[0][k]);
				for (int i = 0; i < 3; i++) begin
					e_s1[k][i] <= D'(vert_q[(k == 2) ? 0 : k + 1][i]) - D'(vert_q[k][i]);
					c_s1[k][i] <= D'(vert_q[(k == 0) ? 2 : k - 1][i]) - D'(vert_q[k][i]);
					q_s1[k][i] <= D'(pw[i]) - D'(vert_q[k][i]);
				end
			end
			// s2: first products
			mn2_s2 <= SQ'(minlen_q) * SQ'(minlen_q);
			nr2_s2 <= SQ'(near_q) * SQ'(near_q);
			for (int i = 0; i < 3; i++) begin
				n_s2[i] <= n_s1[i];
				nsq_s2[i] <= P2'(n_s1[i]) * P2'(n_s1[i]);
				dnp_s2[i] <= P2'(d_s1[i]) * P2'(n_s1[i]);
				for (int k = 0; k < 3; k++) begin
					e_s2[k][i] <= e_s1[k][i];
					c_s2[k][i] <= c_s1[k][i];
					q_s2[k][i] <= q_s1[k][i];
					eep_s2[k][i] <= P2'(e_s1[k][i]) * P2'(e_s1[k][i]);
					cep_s2[k][i] <= P2'(c_s1[k][i]) * P2'(e_s1[k][i]);
				end
			end
			// s3: dot sums, normal length
			nn_s3 <= S2'(nsq_s2[0]) + S2'(nsq_s2[1]) + S2'(nsq_s2[2]);
			dn_s3 <= S2'(dnp_s2[0]) + S2'(dnp_s2[1]) + S2'(dnp_s2[2]);
			ok_s3 <= P6'(S2'(nsq_s2[0]) + S2'(nsq_s2[1]) + S2'(nsq_s2[2]))
				> P6'($signed({1'b0, mn2_s2}));
			nr2_s3 <= nr2_s2;
			for (int k = 0; k < 3; k++) begin
				n_s3[k] <= n_s2[k];
				ee_s3[k] <= S2'(eep_s2[k][0]) + S2'(eep_s2[k][1]) + S2'(eep_s2[k][2]);
				ce_s3[k] <= S2'(cep_s2[k][0]) + S2'(cep_s2[k][1]) + S2'(cep_s2[k][2]);
				for (int i = 0; i < 3; i++) begin
					e_s3[k][i] <= e_s2[k][i];
					c_s3[k][i] <= c_s2[k][i];
					q_s3[k][i] <= q_s2[k][i];
				end
			end
			// s4 to s6: carried alongside the distance and inward vector products
			ok_s4 <= ok_s3;
			ok_s5 <= ok_s4;
			ok_s6 <= ok_s5;
			nn_s4 <= nn_s3;
			nn_s5 <= nn_s4;
			nn_s6 <= nn_s5;
			dn_s4 <= dn_s3;
			dn_s5 <= dn_s4;
			dn_s6 <= dn_s5;
			for (int k = 0; k < 3; k++) begin
				n_s4[k] <= n_s3[k];
				n_s5[k] <= n_s4[k];
				n_s6[k] <= n_s5[k];
				for (int i = 0; i < 3; i++) begin
					c_s4[k][i] <= c_s3[k][i];
					c_s5[k][i] <= c_s4[k][i];
					c_s6[k][i] <= c_s5[k][i];
					q_s4[k][i] <= q_s3[k][i];
					q_s5[k][i] <= q_s4[k][i];
					q_s6[k][i] <= q_s5[k][i];
				end
			end
			// s7: inward vectors, plane distance check
			ok_s7 <= ok_s6 && (nrn_s6 > dn2_s6);
			nn_s7 <= nn_s6;
			dn_s7 <= dn_s6;
			for (int k = 0; k < 3; k++) begin
				n_s7[k] <= n_s6[k];
				for (int i = 0; i < 3; i++) begin
					c_s7[k][i] <= c_s6[k][i];
					q_s7[k][i] <= q_s6[k][i];
					w_s7[k][i] <= ecp_s6[k][i] - cep_s6[k][i];
				end
			end
			// s8 to s10: carried alongside the products with inward vectors
			ok_s8 <= ok_s7;
			ok_s9 <= ok_s8;
			ok_s10 <= ok_s9;
			nn_s8 <= nn_s7;
			nn_s9 <= nn_s8;
			nn_s10 <= nn_s9;
			dn_s8 <= dn_s7;
			dn_s9 <= dn_s8;
			dn_s10 <= dn_s9;
			// s11: sums, degenerate edge check
			nn_s11 <= nn_s10;
			dn_s11 <= dn_s10;
			ok_s11 <= ok_s10
				&& (S4'(cwp_s10[0][0]) + S4'(cwp_s10[0][1]) + S4'(cwp_s10[0][2]) > 0)
				&& (S4'(cwp_s10[1][0]) + S4'(cwp_s10[1][1]) + S4'(cwp_s10[1][2]) > 0)
				&& (S4'(cwp_s10[2][0]) + S4'(cwp_s10[2][1]) + S4'(cwp_s10[2][2]) > 0);
			for (int k = 0; k < 3; k++) begin
				qw_s11[k] <= S4'(qwp_s10[k][0]) + S4'(qwp_s10[k][1]) + S4'(qwp_s10[k][2]);
				nw_s11[k] <= S4'(nwp_s10[k][0]) + S4'(nwp_s10[k][1]) + S4'(nwp_s10[k][2]);
			end
			// s12 to s14: carried alongside the projected side products
			ok_s12 <= ok_s11;
			ok_s13 <= ok_s12;
			ok_s14 <= ok_s13;
			hit_q <= fin_ok;
		end
	end

	assign out_valid = out_valid_q;
	assign hit = hit_q;

endmodule

// File: hdl/point_triangle_proximity_test_core.sv
// top level of the point/triangle proximity test
// depends on ptp_pkg, ptp_front, ptp_queue, ptp_back
//
// input channel (in_valid/in_ready, mode, coord_x/y/z): modes 0..2 load a
// vertex, 3 loads the face normal, 4 tests a point; other modes are dropped.
// output channel (out_valid/out_ready, hit): one transfer per test point, in
// order. loads give no output transfer.
// config port (cfg_we, cfg_addr, cfg_wdata): 0 near distance, 1 minimum
// normal length. the user writes it only while idle; the block does not enforce it.
// throughput: one item per cycle while the receiver does not stall, set by the
// fourteen stage test pipeline whose wide products are split into 32 bit slices
// over three stages. an input transfer is registered in the queue, then in each
// stage of the test pipeline, then in the output register before output valid.
// a stalled receiver freezes the pipeline; the four entry queue keeps taking
// input until it fills, then in_ready drops.
// reset clears the triangle to zero, the registers to 1.0 and 0.5, and
// empties the queue and pipeline.
module point_triangle_proximity_test_core #(
	parameter int COORD_BITS = ptp_pkg::COORD_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [2:0] mode,
	input  logic signed [ptp_pkg::IN_BITS-1:0] coord_x,
	input  logic signed [ptp_pkg::IN_BITS-1:0] coord_y,
	input  logic signed [ptp_pkg::IN_BITS-1:0] coord_z,
	output logic out_valid,
	input  logic out_ready,
	output logic hit,
	input  logic cfg_we,
	input  logic cfg_addr,
	input  logic [ptp_pkg::CFG_BITS-1:0] cfg_wdata
);
	import ptp_pkg::*;

	q_stat_t q_stat;
	item_t push_item, pop_item;
	logic push, pop;

	ptp_front u_front (
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(mode),
		.coord_x(coord_x),
		.coord_y(coord_y),
		.coord_z(coord_z),
		.q_stat(q_stat),
		.push(push),
		.item(push_item)
	);

	ptp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wr_item(push_item),
		.pop(pop),
		.rd_item(pop_item),
		.stat(q_stat)
	);

	ptp_back #(.COORD_BITS(COORD_BITS)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.q_stat(q_stat),
		.item(pop_item),
		.pop(pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.hit(hit)
	);

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.count <= QUEUE_DEPTH)
		else $error("queue count above depth");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.full |-> !in_ready)
		else $error("ready while queue full");

	a_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.empty && !in_valid |=> q_stat.empty)
		else $error("queue filled without a transfer");

endmodule
